@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the battery level estimator.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/ble_pkg.sv @@
// Package for the battery level estimator: widths, register indexes, FSM type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

	localparam int ADC_W     = 12;
	localparam int PCT_W     = 7;
	// averaging ring depth, power of two (2..64)
	localparam int AVG_DEPTH = 8;
	localparam int RING_AW   = $clog2(AVG_DEPTH);
	localparam int SUM_W     = ADC_W + RING_AW;
	// dividend of the percent mapping: (x - lo) * 100
	localparam int NUM_W     = ADC_W + PCT_W;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int PCT_SCALE = 100;
	localparam int PCT_MAX   = 99;
	localparam int CFG_AW    = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_HALVING_MODE = 3'd0,
		REG_BATTERY_TYPE = 3'd1,
		REG_STD_ADC_MIN  = 3'd2,
		REG_STD_ADC_MAX  = 3'd3,
		REG_NEW_ADC_MIN  = 3'd4,
		REG_NEW_ADC_MAX  = 3'd5,
		REG_LOW_PERCENT  = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MAP  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/battery_level_estimator.sv @@
// Battery level estimator top level: smoothing filters, bit-serial percent divider.
// Depends on ble_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Takes one 12-bit ADC sample per beat and returns one beat with the charge
// level (0..99 %), a low flag and the smoothed ADC value. Smoothing is either a
// running halving filter or an 8-deep ring average; a beat with tuser set
// preloads both filters with its sample first. The filters update on the
// accepting edge; S_MAP then sets up the mapping, S_DIV runs the restoring
// divider that retires one quotient bit per cycle, and S_FIN loads the output
// register. With an empty window or a sample at or below the window minimum
// S_MAP skips the divider and goes straight to S_FIN. The next beat is taken
// the cycle after the result is loaded, even if it is not yet taken. A result
// still waiting in the output register when the next one is ready holds the
// block until it is taken. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce it.
module battery_level_estimator
	import ble_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_AW-1:0]    cfg_addr,
	input  wire logic [ADC_W-1:0]     cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,  // [11:0] sample, [15:12] zero
	input  wire logic                 s_tuser,  // [0] prime
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata   // [6:0] level_percent, [7] low_flag,
	                                            // [19:8] smoothed_adc, [23:20] zero
);

	// configuration registers
	logic             halving_mode_q;
	logic             battery_type_q;
	logic [ADC_W-1:0] std_min_q, std_max_q, new_min_q, new_max_q;
	logic [PCT_W-1:0] low_percent_q;

	// filter state
	logic [ADC_W-1:0]   ring_q [AVG_DEPTH];
	logic [RING_AW-1:0] ring_idx_q;
	logic [SUM_W-1:0]   ring_sum_q;
	logic [ADC_W-1:0]   halved_q;

	// datapath
	state_t           state_q;
	logic [ADC_W-1:0] smooth_q;
	logic [NUM_W-1:0] num_q;   // dividend in, quotient out
	logic [ADC_W-1:0] den_q;
	logic [ADC_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;

	logic             m_tvalid_q;
	logic [PCT_W-1:0] out_level_q;
	logic             out_low_q;
	logic [ADC_W-1:0] out_smooth_q;

	logic             accept;
	logic [ADC_W-1:0] s_sample;
	logic             s_prime;
	logic [ADC_W-1:0] old_slot, old_halved;
	logic [SUM_W-1:0] old_sum, new_sum;
	logic [RING_AW-1:0] cur_idx, nxt_idx;
	logic [ADC_W:0]   halved_add;
	logic [ADC_W-1:0] halved_new, smooth_new;
	logic [ADC_W-1:0] win_lo, win_hi;
	logic [ADC_W-1:0] diff;
	logic [ADC_W:0]   trial;
	logic             trial_ge;
	logic [PCT_W-1:0] level;
	logic             out_free;

	assign s_sample = s_tdata[ADC_W-1:0];
	assign s_prime  = s_tuser;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// prime substitutes the sample for every piece of old filter state and restarts the ring index at zero
	always_comb begin
		old_slot   = s_prime ? s_sample : ring_q[ring_idx_q];
		old_sum    = s_prime ? (SUM_W'(s_sample) << RING_AW) : ring_sum_q;
		old_halved = s_prime ? s_sample : halved_q;
		cur_idx    = s_prime ? '0 : ring_idx_q;
		nxt_idx    = (cur_idx == RING_AW'(AVG_DEPTH - 1)) ? '0 : cur_idx + 1'b1;
		new_sum    = old_sum - SUM_W'(old_slot) + SUM_W'(s_sample);
		halved_add = {1'b0, old_halved} + {1'b0, s_sample};
		halved_new = halved_add[ADC_W:1];
		smooth_new = halving_mode_q ? halved_new : new_sum[SUM_W-1:RING_AW];
	end

	always_comb begin
		win_lo   = battery_type_q ? new_min_q : std_min_q;
		win_hi   = battery_type_q ? new_max_q : std_max_q;
		diff     = smooth_q - win_lo;
		trial    = {rem_q, num_q[NUM_W-1]};
		trial_ge = (trial >= {1'b0, den_q});
		if (zero_q)
			level = '0;
		else if (num_q > NUM_W'(PCT_MAX))
			level = PCT_W'(PCT_MAX);
		else
			level = num_q[PCT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halving_mode_q <= 1'b1;
			battery_type_q <= 1'b0;
			std_min_q      <= '0;
			std_max_q      <= '1;
			new_min_q      <= '0;
			new_max_q      <= '1;
			low_percent_q  <= PCT_W'(20);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HALVING_MODE: halving_mode_q <= cfg_wdata[0];
				REG_BATTERY_TYPE: battery_type_q <= cfg_wdata[0];
				REG_STD_ADC_MIN:  std_min_q      <= cfg_wdata;
				REG_STD_ADC_MAX:  std_max_q      <= cfg_wdata;
				REG_NEW_ADC_MIN:  new_min_q      <= cfg_wdata;
				REG_NEW_ADC_MAX:  new_max_q      <= cfg_wdata;
				REG_LOW_PERCENT:  low_percent_q  <= cfg_wdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++)
				ring_q[i] <= '0;
			ring_idx_q <= '0;
			ring_sum_q <= '0;
			halved_q   <= '0;
		end else if (accept) begin
			if (s_prime) begin
				for (int i = 0; i < AVG_DEPTH; i++)
					ring_q[i] <= s_sample;
				ring_idx_q <= '0;
				ring_sum_q <= old_sum;
				halved_q   <= s_sample;
			end
			if (halving_mode_q) begin
				halved_q <= halved_new;
			end else begin
				ring_q[cur_idx] <= s_sample;
				ring_idx_q      <= nxt_idx;
				ring_sum_q      <= new_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_MAP;
				S_MAP: begin
					if (win_hi <= win_lo || smooth_q <= win_lo) begin
						state_q <= S_FIN;
					end else begin
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_FIN;
				end
				S_FIN: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			smooth_q <= smooth_new;
		if (state_q == S_MAP) begin
			zero_q <= (win_hi <= win_lo) || (smooth_q <= win_lo);
			num_q  <= NUM_W'(diff) * NUM_W'(PCT_SCALE);
			den_q  <= win_hi - win_lo;
			rem_q  <= '0;
		end
		if (state_q == S_DIV) begin
			// restoring divide, one quotient bit per cycle
			rem_q <= trial_ge ? ADC_W'(trial - {1'b0, den_q}) : trial[ADC_W-1:0];
			num_q <= {num_q[NUM_W-2:0], trial_ge};
		end
		if (state_q == S_FIN && out_free) begin
			out_level_q  <= level;
			out_low_q    <= (level < low_percent_q);
			out_smooth_q <= smooth_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == S_FIN && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_smooth_q, out_low_q, out_level_q};

	`ASSERT_CLK(a_level_range, !m_tvalid_q || out_level_q <= PCT_W'(PCT_MAX), "level above 99")
	`ASSERT_CLK(a_rem_below_den, state_q != S_DIV || rem_q < den_q, "divider remainder overflow")
	`ASSERT_NEXT(a_accept_to_map, accept, state_q == S_MAP, "accepted beat not mapped")
	`ASSERT_NEXT(a_div_runs, state_q == S_DIV && cnt_q != '0, state_q == S_DIV,
		"divider stopped early")

endmodule

`default_nettype wire

@@ sim/battery_level_estimator_tb.sv @@
// Testbench for battery_level_estimator: directed table, then randomized phases with
// source gaps, sink stalls and a long sink hold-off. Needs ble_pkg and the RTL only.
`timescale 1ns / 1ps

module battery_level_estimator_tb
	import ble_pkg::*;
();

	typedef struct packed {
		logic [PCT_W-1:0] level;
		logic             low;
		logic [ADC_W-1:0] smoothed;
	} level_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,   // register write, block drained first
		ROW_BEAT,    // sample beat, result from the predictor
		ROW_CHECK    // sample beat, result typed in the row
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		reg_idx_t         addr;
		logic [ADC_W-1:0] value;   // sample or register value
		logic             prime;
		logic [PCT_W-1:0] level;
		logic             low;
		logic [ADC_W-1:0] smoothed;
	} plan_row_t;

	localparam int PLAN_LEN = 37;
	localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
		'{ROW_CHECK, REG_HALVING_MODE, 12'd4095, 1'b1, 7'd99, 1'b0, 12'd4095},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd0,    1'b1, 7'd0,  1'b1, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b1, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd4095, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd2048, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd1,    1'b0, 7'd0,  1'b0, 12'd0},
		// ring average; prime also reloads the halving filter
		'{ROW_WRITE, REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd4095, 1'b1, 7'd99, 1'b0, 12'd4095},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd100,  1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd4095, 1'b0, 7'd0,  1'b0, 12'd0},
		// back to halving: filter resumes from its kept value
		'{ROW_WRITE, REG_HALVING_MODE, 12'd1,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		// threshold above the clamp: flag always set
		'{ROW_WRITE, REG_LOW_PERCENT,  12'd127,  1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd4095, 1'b1, 7'd99, 1'b1, 12'd4095},
		'{ROW_WRITE, REG_LOW_PERCENT,  12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd0,    1'b1, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_NEW_ADC_MIN,  12'd1000, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_NEW_ADC_MAX,  12'd3000, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_BATTERY_TYPE, 12'd1,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_LOW_PERCENT,  12'd50,   1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd500,  1'b1, 7'd0,  1'b1, 12'd500},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd3500, 1'b1, 7'd99, 1'b0, 12'd3500},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd2000, 1'b1, 7'd50, 1'b0, 12'd2000},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd1001, 1'b1, 7'd0,  1'b0, 12'd0},
		// max equal to min: empty window
		'{ROW_WRITE, REG_NEW_ADC_MAX,  12'd1000, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd2000, 1'b1, 7'd0,  1'b1, 12'd2000},
		'{ROW_WRITE, REG_BATTERY_TYPE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_STD_ADC_MIN,  12'd4095, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_STD_ADC_MAX,  12'd0,    1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_CHECK, REG_HALVING_MODE, 12'd4095, 1'b1, 7'd0,  1'b1, 12'd4095},
		'{ROW_WRITE, REG_STD_ADC_MIN,  12'd100,  1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_WRITE, REG_STD_ADC_MAX,  12'd4000, 1'b0, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd4095, 1'b1, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd50,   1'b1, 7'd0,  1'b0, 12'd0},
		'{ROW_BEAT,  REG_HALVING_MODE, 12'd0,    1'b0, 7'd0,  1'b0, 12'd0}
	};

	localparam int SETTLE_CYCLES = 30;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_AW-1:0]  cfg_addr;
	logic [ADC_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [15:0]        s_tdata;   // [11:0] sample, [15:12] zero
	logic               s_tuser;   // [0] prime
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;   // [6:0] level_percent, [7] low_flag, [19:8] smoothed_adc

	battery_level_estimator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predictor copy of the registers
	logic             cfg_halving;
	logic             cfg_new_type;
	logic [ADC_W-1:0] cfg_std_lo;
	logic [ADC_W-1:0] cfg_std_hi;
	logic [ADC_W-1:0] cfg_new_lo;
	logic [ADC_W-1:0] cfg_new_hi;
	logic [PCT_W-1:0] cfg_low_pct;

	// predictor copy of the filter state
	logic [ADC_W-1:0]   avg_ring [AVG_DEPTH];
	logic [RING_AW-1:0] avg_ptr;
	logic [SUM_W-1:0]   avg_total;
	logic [ADC_W-1:0]   half_acc;

	level_result_t pending_levels [$];
	int            mismatches;
	int            idle_pct;
	int            stall_pct;
	int            stall_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [PCT_W-1:0] scale_percent(input logic [ADC_W-1:0] x,
			input logic [ADC_W-1:0] lo, input logic [ADC_W-1:0] hi);
		int unsigned pct;
		if (hi <= lo || x <= lo)
			return '0;
		pct = (int'(x - lo) * PCT_SCALE) / int'(hi - lo);
		if (pct > PCT_MAX)
			pct = PCT_MAX;
		return pct[PCT_W-1:0];
	endfunction

	task automatic predict_level(input logic [ADC_W-1:0] s, input logic prime,
			output level_result_t r);
		logic [ADC_W:0]   half_sum;
		logic [ADC_W-1:0] smooth;
		if (prime) begin
			for (int i = 0; i < AVG_DEPTH; i++)
				avg_ring[i] = s;
			avg_total = SUM_W'(s) << RING_AW;
			avg_ptr   = '0;
			half_acc  = s;
		end
		if (cfg_halving) begin
			half_sum = half_acc + s;
			half_acc = half_sum[ADC_W:1];
			smooth   = half_acc;
		end else begin
			avg_total = avg_total - avg_ring[avg_ptr] + s;
			avg_ring[avg_ptr] = s;
			avg_ptr  = (avg_ptr == AVG_DEPTH - 1) ? '0 : avg_ptr + 1'b1;
			smooth   = ADC_W'(avg_total / AVG_DEPTH);
		end
		r.smoothed = smooth;
		r.level    = cfg_new_type ? scale_percent(smooth, cfg_new_lo, cfg_new_hi)
		                          : scale_percent(smooth, cfg_std_lo, cfg_std_hi);
		r.low      = r.level < cfg_low_pct;
	endtask

	// sink side: stall pattern and result checking
	initial begin
		level_result_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_levels.size() == 0) begin
					report_mismatch($sformatf("result beat 0x%06h with nothing pending", m_tdata));
				end else begin
					want = pending_levels.pop_front();
					if (m_tdata[6:0] !== want.level)
						report_mismatch($sformatf("level_percent got %0d expected %0d",
							m_tdata[6:0], want.level));
					if (m_tdata[7] !== want.low)
						report_mismatch($sformatf("low_flag got %0d expected %0d",
							m_tdata[7], want.low));
					if (m_tdata[19:8] !== want.smoothed)
						report_mismatch($sformatf("smoothed_adc got %0d expected %0d",
							m_tdata[19:8], want.smoothed));
				end
			end
			if (stall_hold > 0) begin
				m_tready <= 1'b0;
				stall_hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [ADC_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_HALVING_MODE: cfg_halving  = value[0];
			REG_BATTERY_TYPE: cfg_new_type = value[0];
			REG_STD_ADC_MIN:  cfg_std_lo   = value;
			REG_STD_ADC_MAX:  cfg_std_hi   = value;
			REG_NEW_ADC_MIN:  cfg_new_lo   = value;
			REG_NEW_ADC_MAX:  cfg_new_hi   = value;
			REG_LOW_PERCENT:  cfg_low_pct  = value[PCT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [ADC_W-1:0] s, input logic prime,
			input logic typed, input level_result_t typed_out);
		level_result_t model_out;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, s};
		s_tuser  <= prime;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_level(s, prime, model_out);
		pending_levels.push_back(typed ? typed_out : model_out);
	endtask

	task automatic pick_window(output logic [ADC_W-1:0] lo, output logic [ADC_W-1:0] hi);
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) begin
			// unordered, often empty
			lo = ADC_W'($urandom_range(4095));
			hi = ADC_W'($urandom_range(4095));
		end else if (r == 1) begin
			lo = '0;
			hi = '1;
		end else begin
			lo = ADC_W'($urandom_range(2047));
			hi = ADC_W'(lo + 1 + $urandom_range(4094 - lo));
		end
	endtask

	task automatic pick_setup();
		logic [ADC_W-1:0] lo;
		logic [ADC_W-1:0] hi;
		wait_for_results();
		write_reg(REG_HALVING_MODE, ADC_W'($urandom_range(1)));
		write_reg(REG_BATTERY_TYPE, ADC_W'($urandom_range(1)));
		pick_window(lo, hi);
		write_reg(REG_STD_ADC_MIN, lo);
		write_reg(REG_STD_ADC_MAX, hi);
		pick_window(lo, hi);
		write_reg(REG_NEW_ADC_MIN, lo);
		write_reg(REG_NEW_ADC_MAX, hi);
		if ($urandom_range(9) == 0)
			write_reg(REG_LOW_PERCENT, ADC_W'($urandom_range(127)));
		else
			write_reg(REG_LOW_PERCENT, ADC_W'($urandom_range(PCT_MAX)));
	endtask

	task automatic run_samples(input int count);
		logic [ADC_W-1:0] s;
		int unsigned      r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(15);
			if (r == 0)
				s = '0;
			else if (r == 1)
				s = '1;
			else
				s = ADC_W'($urandom_range(4095));
			send_sample(s, $urandom_range(11) == 0, 1'b0, '0);
		end
	endtask

	initial begin
		int  idle_table [4];
		int  stall_table [4];
		logic prev_write;
		idle_table  = '{0, 61, 0, 19};
		stall_table = '{0, 0, 61, 19};
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_addr   <= '0;
		cfg_wdata  <= '0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= 1'b0;
		mismatches = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		stall_hold = 0;
		cfg_halving  = 1'b1;
		cfg_new_type = 1'b0;
		cfg_std_lo   = '0;
		cfg_std_hi   = '1;
		cfg_new_lo   = '0;
		cfg_new_hi   = '1;
		cfg_low_pct  = 7'd20;
		for (int i = 0; i < AVG_DEPTH; i++)
			avg_ring[i] = '0;
		avg_ptr   = '0;
		avg_total = '0;
		half_acc  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		prev_write = 1'b0;
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				if (!prev_write)
					wait_for_results();
				write_reg(PLAN[i].addr, PLAN[i].value);
				prev_write = 1'b1;
			end else begin
				send_sample(PLAN[i].value, PLAN[i].prime, PLAN[i].kind == ROW_CHECK,
					level_result_t'{PLAN[i].level, PLAN[i].low, PLAN[i].smoothed});
				prev_write = 1'b0;
			end
		end

		for (int p = 0; p < 4; p++) begin
			pick_setup();
			idle_pct  = idle_table[p];
			stall_pct = stall_table[p];
			run_samples(140);
		end

		// sink holds off while the source keeps offering: both stages fill
		pick_setup();
		idle_pct   = 0;
		stall_pct  = 0;
		stall_hold = 300;
		run_samples(60);

		wait_for_results();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
